@@ rtl/dequ_pkg.sv @@
// Shared types and codes for the double-ended queue unit.
// Depends on nothing; every other file imports it.
package dequ_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_HEAD = 2'd0,
        REQ_PUSH_TAIL = 2'd1,
        REQ_POP_HEAD  = 2'd2,
        REQ_POP_TAIL  = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } status_e_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data_out;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       item_count;
        logic                     is_empty;
    } rsp_t;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic tail_push;
    } cell_ctl_t;

endpackage

@@ rtl/dequ_cell.sv @@
// One storage cell of the queue chain; cell zero holds the front word.
// Depends on dequ_pkg.
module dequ_cell #(
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                              aclk,
    input  dequ_pkg::cell_ctl_t               ctl,
    input  logic [CNT_W-1:0]                  item_cnt,
    input  logic signed [dequ_pkg::WORD_W-1:0] push_data,
    input  logic signed [dequ_pkg::WORD_W-1:0] near_data,
    input  logic signed [dequ_pkg::WORD_W-1:0] far_data,
    output logic signed [dequ_pkg::WORD_W-1:0] data_q
);
    import dequ_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_in) begin
            data_next = near_data;
        end else if (ctl.shift_out) begin
            data_next = far_data;
        end else if (ctl.tail_push && (item_cnt == CNT_W'(CELL_IDX))) begin
            data_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit words held in a chain of DEPTH cells.
// Depends on dequ_pkg and dequ_cell.
// The front word always sits in cell zero: a push at the head moves every word one
// cell toward the back, a pop at the head moves every word one cell toward the front,
// and a push at the tail writes the cell just past the last word. A pop at the tail
// reads the last occupied cell. Each result is registered, and a new request
// is accepted every cycle as long as the result register is empty or being drained.
// A pop on an empty queue returns underflow and a push on a full queue returns full;
// both leave the queue unchanged. No clearing pass is needed after reset.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dequ_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output dequ_pkg::rsp_t   m_data
);
    import dequ_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    cell_ctl_t                ctl;

    logic                     accept;
    logic                     is_full;
    logic                     is_none;
    logic [IDX_W-1:0]         tail_idx;
    logic [CNT_W-1:0]         cnt_minus1;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;
    req_e_t                   req;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign req      = req_e_t'(s_data.req_type);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_none  = (count_reg == '0);
    assign cnt_minus1 = count_reg - CNT_W'(1);
    assign tail_idx = cnt_minus1[IDX_W-1:0];

    always_comb begin
        ctl = '0;
        if (accept) begin
            case (req)
                REQ_PUSH_HEAD: ctl.shift_in  = !is_full;
                REQ_PUSH_TAIL: ctl.tail_push = !is_full;
                REQ_POP_HEAD:  ctl.shift_out = !is_none;
                REQ_POP_TAIL:  ctl = '0;
                default:       ctl = '0;
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [WORD_W-1:0] near_d;
        logic signed [WORD_W-1:0] far_d;
        if (i == 0) begin : g_first
            assign near_d = s_data.data_in;
        end else begin : g_mid
            assign near_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign far_d = cell_data[i];
        end else begin : g_inner
            assign far_d = cell_data[i+1];
        end
        dequ_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .item_cnt  (count_reg),
            .push_data (s_data.data_in),
            .near_data (near_d),
            .far_data  (far_d),
            .data_q    (cell_data[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        rsp_next.data_out = '0;
        rsp_next.status   = ST_OK;
        case (req)
            REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
                if (is_full) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_HEAD: begin
                if (is_none) begin
                    rsp_next.status = ST_UNDERFLOW;
                end else begin
                    rsp_next.data_out = cell_data[0];
                    count_next = cnt_minus1;
                end
            end
            REQ_POP_TAIL: begin
                if (is_none) begin
                    rsp_next.status = ST_UNDERFLOW;
                end else begin
                    rsp_next.data_out = cell_data[tail_idx];
                    count_next = cnt_minus1;
                end
            end
            default: begin
                rsp_next.status = ST_OK;
            end
        endcase
        cnt_ext = {{COUNT_W{1'b0}}, count_next};
        rsp_next.item_count = cnt_ext[COUNT_W-1:0];
        rsp_next.is_empty   = (count_next == '0);
        if (!accept) begin
            count_next = count_reg;
            rsp_next   = rsp_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule
